FILE: design/space_packet_command_parser_macros.svh
// assertion macros used by the parser top level
`ifndef SPACE_PACKET_COMMAND_PARSER_MACROS_SVH
`define SPACE_PACKET_COMMAND_PARSER_MACROS_SVH

// same-cycle implication, clocked on clk and held off during reset
`define SPCP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk and held off during reset
`define SPCP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/spcp_pkg.sv
// types and constants shared by the space packet command parser
package spcp_pkg;

	localparam int unsigned HDR_BYTES  = 6;
	localparam int unsigned DATA_BYTES = 4;
	localparam int unsigned CNT_W      = 17;
	localparam int unsigned TBL_REGS   = 3;
	localparam int unsigned TBL_W      = 52;
	localparam int unsigned ENTRY_W    = 13;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	// status codes
	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_SHORT     = 4'd1;
	localparam logic [3:0] ST_VERSION   = 4'd2;
	localparam logic [3:0] ST_LENGTH    = 4'd3;
	localparam logic [3:0] ST_APID      = 4'd4;
	localparam logic [3:0] ST_SEC_FLAG  = 4'd5;
	localparam logic [3:0] ST_CMD_LEN   = 4'd6;
	localparam logic [3:0] ST_REG_INDEX = 4'd7;
	localparam logic [3:0] ST_UNKNOWN   = 4'd8;

	// command kinds
	localparam logic [1:0] KIND_NOOP  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	// command words
	localparam logic [15:0] CMD_NOOP  = 16'd0;
	localparam logic [15:0] CMD_READ  = 16'd256;
	localparam logic [15:0] CMD_WRITE = 16'd257;

	// configuration register indexes
	localparam logic [2:0] REG_TABLE_FIRST  = 3'd0;
	localparam logic [2:0] REG_TABLE_SECOND = 3'd1;
	localparam logic [2:0] REG_TABLE_THIRD  = 3'd2;
	localparam logic [2:0] REG_VERSION      = 3'd3;
	localparam logic [2:0] REG_INDEX_LIMIT  = 3'd4;

	localparam logic [7:0] INDEX_LIMIT_RESET = 8'd15;

	typedef logic [TBL_REGS-1:0][TBL_W-1:0] apid_table_t;

	// one finished packet as the front hands it to the back
	typedef struct packed {
		logic [HDR_BYTES-1:0][7:0]  hdr;
		logic [DATA_BYTES-1:0][7:0] data;
		logic [CNT_W-1:0]           count;
	} packet_rec_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [10:0] apid;
		logic        ptype;
		logic [1:0]  seg_flags;
		logic [13:0] seq_count;
		logic [1:0]  kind;
		logic [7:0]  reg_index;
		logic [7:0]  reg_value;
	} result_t;

endpackage

FILE: design/spcp_fifo.sv
// small first-in first-out queue of words
module spcp_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    fill_q;
	logic             do_push, do_pop;

	assign full    = (fill_q == CW'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/spcp_front.sv
// front end: collects packet bytes and hands a finished packet to the back
module spcp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           packet_byte,
	input  logic                 last_byte,
	output logic                 rec_push,
	output spcp_pkg::packet_rec_t rec
);

	import spcp_pkg::*;

	logic [HDR_BYTES-1:0][7:0]  hdr_q, hdr_n;
	logic [DATA_BYTES-1:0][7:0] data_q, data_n;
	logic [CNT_W-1:0]           count_q, count_n, data_off;

	always_comb begin
		hdr_n    = hdr_q;
		data_n   = data_q;
		data_off = count_q - CNT_W'(HDR_BYTES);
		if (count_q < CNT_W'(HDR_BYTES)) begin
			hdr_n[count_q[2:0]] = packet_byte;
		end else if (count_q < CNT_W'(HDR_BYTES + DATA_BYTES)) begin
			data_n[data_off[1:0]] = packet_byte;
		end
		count_n = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
	end

	assign rec_push  = accept && last_byte;
	assign rec.hdr   = hdr_n;
	assign rec.data  = data_n;
	assign rec.count = count_n;

	always_ff @(posedge clk) begin
		if (accept) begin
			hdr_q <= hdr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			data_q  <= '0;
		end else if (accept) begin
			if (last_byte) begin
				count_q <= '0;
				data_q  <= '0;
			end else begin
				count_q <= count_n;
				data_q  <= data_n;
			end
		end
	end

endmodule

FILE: design/spcp_back.sv
// back end: header checks, apid lookup and command decode for one packet
module spcp_back #(
	parameter int unsigned TABLE_ENTRIES = 12
) (
	input  spcp_pkg::packet_rec_t rec,
	input  spcp_pkg::apid_table_t apid_table,
	input  logic [2:0]            expected_version,
	input  logic [7:0]            index_limit,
	output spcp_pkg::result_t     res
);

	import spcp_pkg::*;

	logic [TBL_REGS*TBL_W-1:0] tbl_flat;
	logic [ENTRY_W-1:0]        entry;
	logic [10:0]               apid;
	logic [15:0]               len, word;
	logic [CNT_W-1:0]          len_plus, data_cnt;
	logic                      found, exp_sec, sflag;
	logic [15:0]               need;
	logic [1:0]                kind;
	logic [7:0]                ridx, rval;

	assign tbl_flat = apid_table;
	assign apid     = {rec.hdr[0][2:0], rec.hdr[1]};
	assign sflag    = rec.hdr[0][3];
	assign len      = {rec.hdr[4], rec.hdr[5]};
	assign len_plus = CNT_W'(len) + 1'b1;
	assign data_cnt = rec.count - CNT_W'(HDR_BYTES);
	assign word     = {rec.data[0], rec.data[1]};

	// first valid matching entry wins, so scan from the top down
	always_comb begin
		found   = 1'b0;
		exp_sec = 1'b0;
		entry   = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			entry = tbl_flat[ENTRY_W*i +: ENTRY_W];
			if (entry[12] && entry[10:0] == apid) begin
				found   = 1'b1;
				exp_sec = entry[11];
			end
		end
	end

	always_comb begin
		kind = KIND_NONE;
		need = '0;
		ridx = '0;
		rval = '0;
		case (word)
			CMD_NOOP: begin
				kind = KIND_NOOP;
				need = 16'd1;
			end
			CMD_READ: begin
				kind = KIND_READ;
				need = 16'd2;
				ridx = rec.data[2];
			end
			CMD_WRITE: begin
				kind = KIND_WRITE;
				need = 16'd3;
				ridx = rec.data[2];
				rval = rec.data[3];
			end
			default: begin
				kind = KIND_NONE;
			end
		endcase
	end

	always_comb begin
		res = '0;
		res.kind = KIND_NONE;
		if (rec.count < CNT_W'(HDR_BYTES)) begin
			res.status = ST_SHORT;
		end else begin
			res.apid      = apid;
			res.ptype     = rec.hdr[0][4];
			res.seg_flags = rec.hdr[2][7:6];
			res.seq_count = {rec.hdr[2][5:0], rec.hdr[3]};
			if (rec.hdr[0][7:5] != expected_version) begin
				res.status = ST_VERSION;
			end else if (len_plus != data_cnt) begin
				res.status = ST_LENGTH;
			end else if (!found) begin
				res.status = ST_APID;
			end else if (sflag != exp_sec) begin
				res.status = ST_SEC_FLAG;
			end else if (kind == KIND_NONE) begin
				res.status = ST_UNKNOWN;
			end else begin
				res.kind      = kind;
				res.reg_index = ridx;
				res.reg_value = rval;
				if (len != need) begin
					res.status = ST_CMD_LEN;
				end else if (kind != KIND_NOOP && ridx > index_limit) begin
					res.status = ST_REG_INDEX;
				end else begin
					res.status = ST_OK;
				end
			end
		end
	end

endmodule

FILE: design/space_packet_command_parser.sv
// space packet command parser top level
//
//  channel   signals                                   direction
//  input     push, full, packet_byte, last_byte        in word, one byte
//  result    pop, empty, status .. register_value      out word, one per packet
//  config    cfg_we, cfg_index, cfg_data               register write
//
// one byte is taken every cycle while push is high and full is low; the front
// collects bytes and on the last byte queues the packet (two deep) for the back
// end. the back end checks one packet per cycle, while the two-deep result queue
// has room, into that queue; a result reaches the ports via the packet then result queue.
// full follows the packet queue and a stalled result queue backs up into it.
// reset clears the byte count, queues, table and version, and sets the index limit to 15.
module space_packet_command_parser #(
	parameter int unsigned TABLE_ENTRIES = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  packet_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  status,
	output logic [10:0] packet_apid,
	output logic        packet_type,
	output logic [1:0]  sequence_flags,
	output logic [13:0] sequence_count,
	output logic [1:0]  command_kind,
	output logic [7:0]  register_index,
	output logic [7:0]  register_value,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [51:0] cfg_data
);

	import spcp_pkg::*;

	`include "space_packet_command_parser_macros.svh"

	apid_table_t table_q;
	logic [2:0]  version_q;
	logic [7:0]  limit_q;

	packet_rec_t rec_in, rec_out;
	result_t     res_in, res_out;
	logic        accept, mid_push, mid_full, mid_empty, back_go, res_full;

	assign accept  = push && !full;
	assign full    = mid_full;
	assign back_go = !mid_empty && !res_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_q   <= '0;
			version_q <= '0;
			limit_q   <= INDEX_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TABLE_FIRST:  table_q[0] <= cfg_data;
				REG_TABLE_SECOND: table_q[1] <= cfg_data;
				REG_TABLE_THIRD:  table_q[2] <= cfg_data;
				REG_VERSION:      version_q  <= cfg_data[2:0];
				REG_INDEX_LIMIT:  limit_q    <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	spcp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.packet_byte (packet_byte),
		.last_byte   (last_byte),
		.rec_push    (mid_push),
		.rec         (rec_in)
	);

	spcp_fifo #(
		.WIDTH ($bits(packet_rec_t)),
		.DEPTH (2)
	) u_pkt_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (rec_in),
		.full   (mid_full),
		.pop    (back_go),
		.rdata  (rec_out),
		.empty  (mid_empty)
	);

	spcp_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.rec              (rec_out),
		.apid_table       (table_q),
		.expected_version (version_q),
		.index_limit      (limit_q),
		.res              (res_in)
	);

	spcp_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (2)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (back_go),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign status         = res_out.status;
	assign packet_apid    = res_out.apid;
	assign packet_type    = res_out.ptype;
	assign sequence_flags = res_out.seg_flags;
	assign sequence_count = res_out.seq_count;
	assign command_kind   = res_out.kind;
	assign register_index = res_out.reg_index;
	assign register_value = res_out.reg_value;

	`SPCP_ASSERT_NOW(a_pkt_no_overflow, mid_push, !mid_full, "packet queue written while full")
	`SPCP_ASSERT_NEXT(a_pkt_queued, mid_push, !mid_empty, "finished packet not queued")
	`SPCP_ASSERT_NEXT(a_result_queued, back_go, !empty, "checked packet left no result")

endmodule
